// File: rtl/pba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pba_pkg - shared definitions of the page bitmap allocator
// Default sizes, item kind codes, flag bit positions and the control
// structs between the sequencer and the bitmap word cache.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int NUM_PAGES_D     = 65536;
    localparam int STACK_DEPTH_D   = 1024;
    localparam int MAP_WORD_BITS_D = 64;
    localparam int PAGE_SHIFT_D    = 12;

    localparam logic [1:0] K_ALLOC = 2'd0;
    localparam logic [1:0] K_FREE  = 2'd1;
    localparam logic [1:0] K_STAT  = 2'd2;

    localparam int F_A64 = 0;
    localparam int F_A16 = 1;
    localparam int F_16M = 2;
    localparam int F_1M  = 3;

    typedef struct packed {
        logic act;
        logic wr;
        logic val;
    } t_map_req;

    typedef struct packed {
        logic busy;
        logic hit;
        logic free_bit;
    } t_map_rsp;

endpackage
`default_nettype wire

// File: rtl/pba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pba_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/pba_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pba_map - free-page bitmap with a one-word cache
// Holds the bitmap RAM, clears it after reset, and serves single-page
// bit reads and writes through a write-back word cache.
// ----------------------------------------------------------------------------
module pba_map
    import pba_pkg::*;
#(
    parameter int NUM_PAGES     = NUM_PAGES_D,
    parameter int MAP_WORD_BITS = MAP_WORD_BITS_D,
    parameter int PW            = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_map_req      i_req,
    input  wire logic [PW-1:0] i_pg,
    output t_map_rsp           o_rsp
);

    localparam int MAP_WORDS = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WIW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(MAP_WORD_BITS);

    logic                     r_clr;
    logic [WIW-1:0]           r_ci;
    logic                     r_wv;
    logic [WIW-1:0]           r_wi;
    logic [MAP_WORD_BITS-1:0] r_wd;
    logic                     r_dirty;
    logic                     r_fetch;
    logic [WIW-1:0]           r_fi;

    logic [WIW-1:0]           widx;
    logic [BW-1:0]            bidx;
    logic                     hit_raw;
    logic                     ram_we;
    logic [WIW-1:0]           ram_wa;
    logic [MAP_WORD_BITS-1:0] ram_wd;
    logic                     ram_re;
    logic [MAP_WORD_BITS-1:0] ram_rd;

    assign widx    = i_pg[BW +: WIW];
    assign bidx    = i_pg[BW-1:0];
    assign hit_raw = r_wv && (r_wi == widx) && !r_fetch && !r_clr;

    assign o_rsp.busy     = r_clr;
    assign o_rsp.hit      = hit_raw;
    assign o_rsp.free_bit = r_wd[bidx];

    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_wi;
        ram_wd = r_wd;
        ram_re = 1'b0;
        if (r_clr) begin
            ram_we = 1'b1;
            ram_wa = r_ci;
            ram_wd = '0;
        end else if (i_req.act && !r_fetch && !hit_raw) begin
            ram_we = r_wv && r_dirty;
            ram_re = 1'b1;
        end
    end

    pba_ram #(
        .WIDTH(MAP_WORD_BITS),
        .DEPTH(MAP_WORDS),
        .AW   (WIW)
    ) u_map_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wa),
        .i_wdata(ram_wd),
        .i_re   (ram_re),
        .i_raddr(widx),
        .o_rdata(ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= 1'b1;
            r_ci    <= '0;
            r_wv    <= 1'b0;
            r_dirty <= 1'b0;
            r_fetch <= 1'b0;
        end else if (r_clr) begin
            r_ci <= r_ci + 1'b1;
            r_wv <= 1'b0;
            if (r_ci == WIW'(MAP_WORDS - 1)) begin
                r_clr <= 1'b0;
            end
        end else if (i_req.act) begin
            if (r_fetch) begin
                r_wd    <= ram_rd;
                r_wi    <= r_fi;
                r_wv    <= 1'b1;
                r_dirty <= 1'b0;
                r_fetch <= 1'b0;
            end else if (hit_raw) begin
                if (i_req.wr) begin
                    r_wd[bidx] <= i_req.val;
                    r_dirty    <= 1'b1;
                end
            end else begin
                r_fetch <= 1'b1;
                r_fi    <= widx;
                r_wv    <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/page_bitmap_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_bitmap_allocator - free-page bitmap allocator
// Allocates, frees and surveys physical pages held in a bitmap, with a
// stack of recently freed pages for single-page requests.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        sink       i_in_valid / o_in_stall    kind, page_count, base_page,
//                                                  alloc_flags
//  out       source     o_out_valid / i_out_stall  status, page, free_runs,
//                                                  free_total, largest_run
//
//  One page is visited per cycle while its word is in the one-word bitmap
//  cache; each change of bitmap word adds a write-back of the dirty word
//  and a fetch of the new one. Free visits page_count pages; allocate scans
//  pages (or pops the stack) and then marks them; stats visits every page.
//  After reset a clearing pass zeroes every bitmap word before the first
//  item is taken. A held result does not block taking the next item.
// ----------------------------------------------------------------------------
module page_bitmap_allocator
    import pba_pkg::*;
#(
    parameter int NUM_PAGES     = NUM_PAGES_D,
    parameter int STACK_DEPTH   = STACK_DEPTH_D,
    parameter int MAP_WORD_BITS = MAP_WORD_BITS_D,
    parameter int PAGE_SHIFT    = PAGE_SHIFT_D
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [15:0] i_page_count,
    input  wire logic [15:0] i_base_page,
    input  wire logic [3:0]  i_alloc_flags,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_status,
    output logic [15:0]      o_page,
    output logic [15:0]      o_free_runs,
    output logic [16:0]      o_free_total,
    output logic [16:0]      o_largest_run
);

    localparam int PGB = $clog2(NUM_PAGES);
    localparam int CW  = (PGB + 1 > 17) ? PGB + 1 : 17;
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW  = $clog2(STACK_DEPTH + 1);
    localparam int A64 = (64 * 1024) >> PAGE_SHIFT;
    localparam int A16 = (16 * 1024) >> PAGE_SHIFT;
    localparam int L16 = (16 * 1024 * 1024) >> PAGE_SHIFT;
    localparam int L1  = (1 * 1024 * 1024) >> PAGE_SHIFT;
    localparam int T16 = (L16 - 1 < NUM_PAGES - 1) ? L16 - 1 : NUM_PAGES - 1;
    localparam int T1  = (L1 - 1 < NUM_PAGES - 1) ? L1 - 1 : NUM_PAGES - 1;

    localparam logic [CW-1:0] C_TOTAL = CW'(NUM_PAGES);
    localparam logic [CW-1:0] C_TOP   = CW'(NUM_PAGES - 1);
    localparam logic [CW-1:0] C_T16   = CW'(T16);
    localparam logic [CW-1:0] C_T1    = CW'(T1);
    localparam logic [CW-1:0] C_A64   = CW'(A64);
    localparam logic [CW-1:0] C_A16   = CW'(A16);
    localparam logic [FW-1:0] C_DEPTH = FW'(STACK_DEPTH);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_POPRD = 4'd2;
    localparam logic [3:0] S_POPWT = 4'd3;
    localparam logic [3:0] S_POPCK = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_MARK  = 4'd6;
    localparam logic [3:0] S_REL   = 4'd7;
    localparam logic [3:0] S_STAT  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0]     r_state, n_state;
    logic [CW-1:0]  r_pg, n_pg;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  r_len, n_len;
    logic [CW-1:0]  r_top, n_top;
    logic [CW-1:0]  r_start, n_start;
    logic [CW-1:0]  r_mem, n_mem;
    logic [CW-1:0]  r_align, n_align;
    logic           r_pass, n_pass;
    logic           r_hd, n_hd;
    logic [CW-1:0]  r_run, n_run;
    logic [CW-1:0]  r_runs, n_runs;
    logic [CW-1:0]  r_total, n_total;
    logic [CW-1:0]  r_largest, n_largest;
    logic [FW-1:0]  r_fill, n_fill;
    logic [PGB-1:0] r_ls, n_ls;
    logic           r_lsv, n_lsv;
    logic           r_rs, n_rs;
    logic [15:0]    r_rpage, n_rpage;
    logic           r_ovalid, n_ovalid;
    logic           r_status;
    logic [15:0]    r_page;
    logic [15:0]    r_oruns;
    logic [16:0]    r_ototal;
    logic [16:0]    r_olarg;

    t_map_req       mreq;
    t_map_rsp       mrsp;
    logic           st_we;
    logic           st_re;
    logic [PGB-1:0] st_rd;
    logic [CW-1:0]  off;
    logic [CW-1:0]  head;
    logic [CW-1:0]  cl_runs;
    logic [CW-1:0]  cl_total;
    logic [CW-1:0]  cl_larg;
    logic [CW-1:0]  sel_top;
    logic [CW-1:0]  sel_align;
    logic           fin_load;

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_status      = r_status;
    assign o_page        = r_page;
    assign o_free_runs   = r_oruns;
    assign o_free_total  = r_ototal;
    assign o_largest_run = r_olarg;

    assign off      = r_mem & (r_align - 1'b1);
    assign head     = r_align - off;
    assign cl_runs  = r_runs + CW'(r_run != '0);
    assign cl_total = r_total + r_run;
    assign cl_larg  = (r_run > r_largest) ? r_run : r_largest;
    assign fin_load = (r_state == S_FIN) && (!r_ovalid || !i_out_stall);

    always_comb begin
        sel_align = '0;
        if (i_alloc_flags[F_A64]) begin
            sel_align = C_A64;
        end else if (i_alloc_flags[F_A16]) begin
            sel_align = C_A16;
        end
        if (i_alloc_flags[F_16M]) begin
            sel_top = C_T16;
        end else if (i_alloc_flags[F_1M]) begin
            sel_top = C_T1;
        end else begin
            sel_top = C_TOP;
        end
    end

    always_comb begin
        mreq.act = 1'b0;
        mreq.wr  = 1'b0;
        mreq.val = 1'b0;
        case (r_state)
            S_POPCK, S_SCAN: mreq.act = 1'b1;
            S_MARK: begin
                mreq.act = (r_cnt != '0);
                mreq.wr  = 1'b1;
            end
            S_REL: begin
                mreq.act = (r_cnt != '0) && (r_pg < C_TOTAL);
                mreq.wr  = 1'b1;
                mreq.val = 1'b1;
            end
            S_STAT: mreq.act = (r_pg < C_TOTAL);
            default: mreq.act = 1'b0;
        endcase
    end

    pba_map #(
        .NUM_PAGES    (NUM_PAGES),
        .MAP_WORD_BITS(MAP_WORD_BITS),
        .PW           (CW)
    ) u_map (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mreq),
        .i_pg   (r_pg),
        .o_rsp  (mrsp)
    );

    assign st_re = (r_state == S_POPRD);
    assign st_we = (r_state == S_REL) && mreq.act && mrsp.hit && (r_fill < C_DEPTH);

    pba_ram #(
        .WIDTH(PGB),
        .DEPTH(STACK_DEPTH),
        .AW   (SAW)
    ) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(r_fill[SAW-1:0]),
        .i_wdata(r_pg[PGB-1:0]),
        .i_re   (st_re),
        .i_raddr(SAW'(r_fill - 1'b1)),
        .o_rdata(st_rd)
    );

    always_comb begin
        n_state   = r_state;
        n_pg      = r_pg;
        n_cnt     = r_cnt;
        n_len     = r_len;
        n_top     = r_top;
        n_start   = r_start;
        n_mem     = r_mem;
        n_align   = r_align;
        n_pass    = r_pass;
        n_hd      = r_hd;
        n_run     = r_run;
        n_runs    = r_runs;
        n_total   = r_total;
        n_largest = r_largest;
        n_fill    = r_fill;
        n_ls      = r_ls;
        n_lsv     = r_lsv;
        n_rs      = r_rs;
        n_rpage   = r_rpage;
        n_ovalid  = r_ovalid && i_out_stall;

        case (r_state)
            S_CLR: begin
                if (!mrsp.busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rs      = 1'b0;
                    n_rpage   = '0;
                    n_runs    = '0;
                    n_total   = '0;
                    n_largest = '0;
                    n_run     = '0;
                    n_pass    = 1'b0;
                    n_hd      = 1'b0;
                    case (i_kind)
                        K_ALLOC: begin
                            n_align = sel_align;
                            n_len   = CW'(i_page_count) + sel_align;
                            n_top   = sel_top;
                            if (r_lsv && (CW'(r_ls) < sel_top)) begin
                                n_start = CW'(r_ls);
                            end else begin
                                n_start = sel_top;
                            end
                            n_pg = n_start;
                            if (i_page_count == '0) begin
                                n_rs    = 1'b1;
                                n_state = S_FIN;
                            end else if (!i_alloc_flags[F_16M] && !i_alloc_flags[F_1M]
                                         && (n_len == CW'(1)) && (r_fill != '0)) begin
                                n_state = S_POPRD;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        K_FREE: begin
                            n_pg    = CW'(i_base_page);
                            n_cnt   = CW'(i_page_count);
                            n_state = S_REL;
                        end
                        K_STAT: begin
                            n_pg    = '0;
                            n_state = S_STAT;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_POPRD: begin
                n_fill  = r_fill - 1'b1;
                n_state = S_POPWT;
            end
            S_POPWT: begin
                n_pg    = CW'(st_rd);
                n_state = S_POPCK;
            end
            S_POPCK: begin
                if (mrsp.hit) begin
                    if (mrsp.free_bit) begin
                        n_mem   = r_pg;
                        n_cnt   = r_len;
                        n_state = S_MARK;
                    end else if (r_fill != '0) begin
                        n_state = S_POPRD;
                    end else begin
                        n_pg    = r_start;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (mrsp.hit) begin
                    if (mrsp.free_bit && (r_run + 1'b1 == r_len)) begin
                        n_mem   = r_pg;
                        n_cnt   = r_len;
                        n_state = S_MARK;
                    end else begin
                        n_run = mrsp.free_bit ? r_run + 1'b1 : '0;
                        if (r_pg == '0) begin
                            if (!r_pass) begin
                                n_pass = 1'b1;
                                n_pg   = r_top;
                                n_run  = '0;
                            end else begin
                                n_rs    = 1'b1;
                                n_state = S_FIN;
                            end
                        end else begin
                            n_pg = r_pg - 1'b1;
                        end
                    end
                end
            end
            S_MARK: begin
                if (r_cnt == '0) begin
                    n_ls  = r_mem[PGB-1:0];
                    n_lsv = 1'b1;
                    if ((r_align != '0) && (off != '0)) begin
                        n_pg    = r_mem;
                        n_cnt   = head;
                        n_mem   = r_mem + head;
                        n_hd    = 1'b1;
                        n_state = S_REL;
                    end else begin
                        n_rpage = r_mem[15:0];
                        n_state = S_FIN;
                    end
                end else if (mrsp.hit) begin
                    n_pg  = r_pg + 1'b1;
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_REL: begin
                if (!mreq.act) begin
                    n_rpage = r_hd ? r_mem[15:0] : '0;
                    n_state = S_FIN;
                end else if (mrsp.hit) begin
                    if (st_we) begin
                        n_fill = r_fill + 1'b1;
                    end
                    n_pg  = r_pg + 1'b1;
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_STAT: begin
                if (!mreq.act) begin
                    n_runs    = cl_runs;
                    n_total   = cl_total;
                    n_largest = cl_larg;
                    n_state   = S_FIN;
                end else if (mrsp.hit) begin
                    if (mrsp.free_bit) begin
                        n_run = r_run + 1'b1;
                    end else begin
                        n_runs    = cl_runs;
                        n_total   = cl_total;
                        n_largest = cl_larg;
                        n_run     = '0;
                    end
                    n_pg = r_pg + 1'b1;
                end
            end
            S_FIN: begin
                if (fin_load) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_fill   <= '0;
            r_lsv    <= 1'b0;
            r_ls     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_lsv    <= n_lsv;
            r_ls     <= n_ls;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pg      <= n_pg;
        r_cnt     <= n_cnt;
        r_len     <= n_len;
        r_top     <= n_top;
        r_start   <= n_start;
        r_mem     <= n_mem;
        r_align   <= n_align;
        r_pass    <= n_pass;
        r_hd      <= n_hd;
        r_run     <= n_run;
        r_runs    <= n_runs;
        r_total   <= n_total;
        r_largest <= n_largest;
        r_rs      <= n_rs;
        r_rpage   <= n_rpage;
        if (fin_load) begin
            r_status <= r_rs;
            r_page   <= r_rpage;
            r_oruns  <= r_runs[15:0];
            r_ototal <= r_total[16:0];
            r_olarg  <= r_largest[16:0];
        end
    end

endmodule
`default_nettype wire
